FILE: rtl/quaternion_product_and_rotate_macros.svh
// Assertion macros for the quaternion unit.
// QPR_ASSERT checks a property on every rising clock edge outside reset.
// QPR_NEVER checks that a condition is never true outside reset.
`ifndef QUATERNION_PRODUCT_AND_ROTATE_MACROS_SVH
`define QUATERNION_PRODUCT_AND_ROTATE_MACROS_SVH

`ifndef SYNTH
`define QPR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("qpr assertion failed");
`define QPR_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("qpr forbidden condition seen");
`else
`define QPR_ASSERT(lbl, clk, rst, prop)
`define QPR_NEVER(lbl, clk, rst, expr)
`endif

`endif

FILE: rtl/qpr_pkg.sv
package qpr_pkg;

  localparam int DATA_W        = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int P_W           = 2 * DATA_W;   // a_i * b_j
  localparam int S_W           = P_W + 2;      // sum of four products

  localparam logic OP_PRODUCT = 1'b0;
  localparam logic OP_ROTATE  = 1'b1;

  typedef struct packed {
    logic valid;
    logic rot;
  } qpr_ctl_t;

  // width of a rounded t = round(2c / 2^F) term, c a difference of two products
  function automatic int t_width(input int frac_bits);
    return S_W + 1 - frac_bits;
  endfunction

endpackage

FILE: rtl/qpr_mul_bank.sv
module qpr_mul_bank (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  qpr_pkg::qpr_ctl_t              ctl_in,
  input  logic signed [qpr_pkg::DATA_W-1:0] a [4],
  input  logic signed [qpr_pkg::DATA_W-1:0] b [4],
  output qpr_pkg::qpr_ctl_t              ctl_out,
  output logic signed [qpr_pkg::P_W-1:0]    p [4][4],
  output logic signed [qpr_pkg::DATA_W-1:0] a_q [4],
  output logic signed [qpr_pkg::DATA_W-1:0] v_q [3]
);
  import qpr_pkg::*;

  // all sixteen a_i*b_j; the rotate cross terms are a subset
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        a_q[i] <= a[i];
        for (int j = 0; j < 4; j++) begin
          p[i][j] <= P_W'(a[i]) * P_W'(b[j]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        v_q[k] <= b[k+1];
      end
    end
  end

endmodule

FILE: rtl/qpr_combine.sv
module qpr_combine #(
  parameter int FRAC_BITS = qpr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  qpr_pkg::qpr_ctl_t                 ctl_in,
  input  logic signed [qpr_pkg::P_W-1:0]    p [4][4],
  input  logic signed [qpr_pkg::DATA_W-1:0] a_in [4],
  input  logic signed [qpr_pkg::DATA_W-1:0] v_in [3],
  output qpr_pkg::qpr_ctl_t                 ctl_out,
  output logic signed [qpr_pkg::S_W-1:0]    s [4],
  output logic signed [qpr_pkg::t_width(FRAC_BITS)-1:0] t [3],
  output logic signed [qpr_pkg::DATA_W-1:0] a_q [4],
  output logic signed [qpr_pkg::DATA_W-1:0] v_q [3]
);
  import qpr_pkg::*;

  localparam int T_W = t_width(FRAC_BITS);
  localparam int C_W = S_W + 1;
  localparam logic signed [C_W-1:0] HALF =
    {{(C_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic signed [S_W-1:0] s_next [4];
  logic signed [C_W-1:0] c [3];
  logic signed [C_W-1:0] c_rnd [3];

  always_comb begin
    // Hamilton product sums
    s_next[0] = S_W'(p[0][0]) - S_W'(p[1][1]) - S_W'(p[2][2]) - S_W'(p[3][3]);
    s_next[1] = S_W'(p[0][1]) + S_W'(p[1][0]) + S_W'(p[2][3]) - S_W'(p[3][2]);
    s_next[2] = S_W'(p[0][2]) - S_W'(p[1][3]) + S_W'(p[2][0]) + S_W'(p[3][1]);
    s_next[3] = S_W'(p[0][3]) + S_W'(p[1][2]) - S_W'(p[2][1]) + S_W'(p[3][0]);
    // a.xyz x v
    c[0] = C_W'(p[2][3]) - C_W'(p[3][2]);
    c[1] = C_W'(p[3][1]) - C_W'(p[1][3]);
    c[2] = C_W'(p[1][2]) - C_W'(p[2][1]);
    for (int k = 0; k < 3; k++) begin
      c_rnd[k] = ((c[k] <<< 1) + HALF) >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s[i]   <= s_next[i];
        a_q[i] <= a_in[i];
      end
      for (int k = 0; k < 3; k++) begin
        t[k]   <= c_rnd[k][T_W-1:0];
        v_q[k] <= v_in[k];
      end
    end
  end

endmodule

FILE: rtl/qpr_rot_mul.sv
module qpr_rot_mul #(
  parameter int FRAC_BITS = qpr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  qpr_pkg::qpr_ctl_t                 ctl_in,
  input  logic signed [qpr_pkg::S_W-1:0]    s_in [4],
  input  logic signed [qpr_pkg::t_width(FRAC_BITS)-1:0] t [3],
  input  logic signed [qpr_pkg::DATA_W-1:0] a [4],
  input  logic signed [qpr_pkg::DATA_W-1:0] v_in [3],
  output qpr_pkg::qpr_ctl_t                 ctl_out,
  output logic signed [qpr_pkg::S_W-1:0]    s_q [4],
  output logic signed [qpr_pkg::DATA_W-1:0] v_q [3],
  output logic signed [qpr_pkg::DATA_W+qpr_pkg::t_width(FRAC_BITS)-1:0] m_w [3],
  output logic signed [qpr_pkg::DATA_W+qpr_pkg::t_width(FRAC_BITS)-1:0] m_pos [3],
  output logic signed [qpr_pkg::DATA_W+qpr_pkg::t_width(FRAC_BITS)-1:0] m_neg [3]
);
  import qpr_pkg::*;

  localparam int M_W = DATA_W + t_width(FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  // a_w*t and the two halves of a.xyz x t
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m_w[k] <= M_W'(a[0]) * M_W'(t[k]);
        v_q[k] <= v_in[k];
      end
      m_pos[0] <= M_W'(a[2]) * M_W'(t[2]);
      m_neg[0] <= M_W'(a[3]) * M_W'(t[1]);
      m_pos[1] <= M_W'(a[3]) * M_W'(t[0]);
      m_neg[1] <= M_W'(a[1]) * M_W'(t[2]);
      m_pos[2] <= M_W'(a[1]) * M_W'(t[1]);
      m_neg[2] <= M_W'(a[2]) * M_W'(t[0]);
      for (int i = 0; i < 4; i++) begin
        s_q[i] <= s_in[i];
      end
    end
  end

endmodule

FILE: rtl/qpr_finish.sv
module qpr_finish #(
  parameter int FRAC_BITS = qpr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  qpr_pkg::qpr_ctl_t                 ctl_in,
  input  logic signed [qpr_pkg::S_W-1:0]    s [4],
  input  logic signed [qpr_pkg::DATA_W-1:0] v [3],
  input  logic signed [qpr_pkg::DATA_W+qpr_pkg::t_width(FRAC_BITS)-1:0] m_w [3],
  input  logic signed [qpr_pkg::DATA_W+qpr_pkg::t_width(FRAC_BITS)-1:0] m_pos [3],
  input  logic signed [qpr_pkg::DATA_W+qpr_pkg::t_width(FRAC_BITS)-1:0] m_neg [3],
  output qpr_pkg::qpr_ctl_t                 ctl_out,
  output logic signed [qpr_pkg::DATA_W-1:0] r [4]
);
  import qpr_pkg::*;

  localparam int M_W  = DATA_W + t_width(FRAC_BITS);
  localparam int V_W  = DATA_W + FRAC_BITS;
  localparam int FA_W = ((M_W > V_W) ? M_W : V_W) + 3;
  localparam int FW   = (FA_W > S_W + 2) ? FA_W : S_W + 2;

  localparam logic signed [FW-1:0] HALF =
    {{(FW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [FW-1:0] MAXV =
    {{(FW-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [FW-1:0] MINV =
    {{(FW-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  logic signed [FW-1:0]     acc [4];
  logic signed [FW-1:0]     rnd [4];
  logic signed [DATA_W-1:0] r_next [4];

  always_comb begin
    acc[0] = FW'(s[0]);
    for (int k = 0; k < 3; k++) begin
      if (ctl_in.rot == OP_ROTATE) begin
        acc[k+1] = (FW'(v[k]) <<< FRAC_BITS) + FW'(m_w[k]) + FW'(m_pos[k])
                   - FW'(m_neg[k]);
      end else begin
        acc[k+1] = FW'(s[k+1]);
      end
    end
    for (int i = 0; i < 4; i++) begin
      rnd[i] = (acc[i] + HALF) >>> FRAC_BITS;
      if (rnd[i] > MAXV) begin
        r_next[i] = MAXV[DATA_W-1:0];
      end else if (rnd[i] < MINV) begin
        r_next[i] = MINV[DATA_W-1:0];
      end else begin
        r_next[i] = rnd[i][DATA_W-1:0];
      end
    end
    if (ctl_in.rot == OP_ROTATE) begin
      r_next[0] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        r[i] <= r_next[i];
      end
    end
  end

endmodule

FILE: rtl/quaternion_product_and_rotate.sv
// Fixed-point quaternion unit, signed Q2.14 (FRAC_BITS fraction bits) in 16 bits.
// Input channel: in_valid / in_stall carry one word: req_type plus quaternion a
// (a_w..a_z) and operand b (b_w..b_z). req_type 0 gives the Hamilton product a*b,
// req_type 1 rotates (b_x, b_y, b_z) by a and returns r_w = 0.
// Output channel: out_valid / out_stall carry r_w..r_z, rounded half up, saturated.
// Throughput: one word per cycle, sustained while out_stall is low, set by a four-stage pipeline:
//   1) 16x16 multiplier bank, 2) product sums and the rounded t = 2(a x v),
//   3) a_w*t and a x t multipliers, 4) final add, round and saturate.
// The edge that accepts a word loads stage 1; the word then moves through stages
// 2, 3 and 4, and its result is on the output once stage 4 holds it.
// Each stage holds its own valid bit; a stage loads when it is empty or the
// next one moves, so bubbles collapse and a stall loses and repeats nothing.
// When the receiver stalls, the result stays on the output and in_stall rises
// only once all four stages are full.
// Reset (synchronous, active high) empties the pipeline; nothing is pending.
`include "quaternion_product_and_rotate_macros.svh"

module quaternion_product_and_rotate #(
  parameter int FRAC_BITS = qpr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic signed [qpr_pkg::DATA_W-1:0] a_w,
  input  logic signed [qpr_pkg::DATA_W-1:0] a_x,
  input  logic signed [qpr_pkg::DATA_W-1:0] a_y,
  input  logic signed [qpr_pkg::DATA_W-1:0] a_z,
  input  logic signed [qpr_pkg::DATA_W-1:0] b_w,
  input  logic signed [qpr_pkg::DATA_W-1:0] b_x,
  input  logic signed [qpr_pkg::DATA_W-1:0] b_y,
  input  logic signed [qpr_pkg::DATA_W-1:0] b_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [qpr_pkg::DATA_W-1:0] r_w,
  output logic signed [qpr_pkg::DATA_W-1:0] r_x,
  output logic signed [qpr_pkg::DATA_W-1:0] r_y,
  output logic signed [qpr_pkg::DATA_W-1:0] r_z
);
  import qpr_pkg::*;

  localparam int T_W = t_width(FRAC_BITS);
  localparam int M_W = DATA_W + T_W;

  // stage enables, back to front
  logic en1, en2, en3, en4;

  // every stage holds a word
  logic pipe_full;

  qpr_ctl_t in_ctl, mul_ctl, cmb_ctl, rot_ctl, fin_ctl;

  logic signed [DATA_W-1:0] a_in [4];
  logic signed [DATA_W-1:0] b_in [4];

  // stage 1 outputs
  logic signed [P_W-1:0]    p1 [4][4];
  logic signed [DATA_W-1:0] a1 [4];
  logic signed [DATA_W-1:0] v1 [3];
  // stage 2 outputs
  logic signed [S_W-1:0]    s2 [4];
  logic signed [T_W-1:0]    t2 [3];
  logic signed [DATA_W-1:0] a2 [4];
  logic signed [DATA_W-1:0] v2 [3];
  // stage 3 outputs
  logic signed [S_W-1:0]    s3 [4];
  logic signed [DATA_W-1:0] v3 [3];
  logic signed [M_W-1:0]    mw3 [3];
  logic signed [M_W-1:0]    mp3 [3];
  logic signed [M_W-1:0]    mn3 [3];
  // stage 4 outputs
  logic signed [DATA_W-1:0] r4 [4];

  assign en4 = !fin_ctl.valid || !out_stall;
  assign en3 = !rot_ctl.valid || en4;
  assign en2 = !cmb_ctl.valid || en3;
  assign en1 = !mul_ctl.valid || en2;

  assign in_stall = !en1;

  assign pipe_full = mul_ctl.valid && cmb_ctl.valid && rot_ctl.valid && fin_ctl.valid;

  assign in_ctl.valid = in_valid;
  assign in_ctl.rot   = req_type;

  assign a_in[0] = a_w;
  assign a_in[1] = a_x;
  assign a_in[2] = a_y;
  assign a_in[3] = a_z;
  assign b_in[0] = b_w;
  assign b_in[1] = b_x;
  assign b_in[2] = b_y;
  assign b_in[3] = b_z;

  qpr_mul_bank u_mul (
    .clk     (clk),
    .rst     (rst),
    .en      (en1),
    .ctl_in  (in_ctl),
    .a       (a_in),
    .b       (b_in),
    .ctl_out (mul_ctl),
    .p       (p1),
    .a_q     (a1),
    .v_q     (v1)
  );

  qpr_combine #(.FRAC_BITS(FRAC_BITS)) u_cmb (
    .clk     (clk),
    .rst     (rst),
    .en      (en2),
    .ctl_in  (mul_ctl),
    .p       (p1),
    .a_in    (a1),
    .v_in    (v1),
    .ctl_out (cmb_ctl),
    .s       (s2),
    .t       (t2),
    .a_q     (a2),
    .v_q     (v2)
  );

  qpr_rot_mul #(.FRAC_BITS(FRAC_BITS)) u_rot (
    .clk     (clk),
    .rst     (rst),
    .en      (en3),
    .ctl_in  (cmb_ctl),
    .s_in    (s2),
    .t       (t2),
    .a       (a2),
    .v_in    (v2),
    .ctl_out (rot_ctl),
    .s_q     (s3),
    .v_q     (v3),
    .m_w     (mw3),
    .m_pos   (mp3),
    .m_neg   (mn3)
  );

  qpr_finish #(.FRAC_BITS(FRAC_BITS)) u_fin (
    .clk     (clk),
    .rst     (rst),
    .en      (en4),
    .ctl_in  (rot_ctl),
    .s       (s3),
    .v       (v3),
    .m_w     (mw3),
    .m_pos   (mp3),
    .m_neg   (mn3),
    .ctl_out (fin_ctl),
    .r       (r4)
  );

  assign out_valid = fin_ctl.valid;
  assign r_w = r4[0];
  assign r_x = r4[1];
  assign r_y = r4[2];
  assign r_z = r4[3];

  // input blocks only with every stage full and the output stalled
  `QPR_ASSERT(a_stall_full, clk, rst, in_stall |-> (pipe_full && out_stall))
  // a free output never backs up into the input
  `QPR_NEVER(a_no_block, clk, rst, in_stall && !out_stall)
  // rotate words carry a zero scalar part
  `QPR_ASSERT(a_rot_w_zero, clk, rst, (out_valid && fin_ctl.rot == OP_ROTATE) |-> (r_w == '0))

endmodule
